### hdl/tcce_pkg.sv
// Shared types and constants of the text console character engine.
`timescale 1ns / 1ps

package tcce_pkg;

   // Screen geometry and field widths.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CELL_W  = 11;
   localparam int CODE_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int DATA_W  = 16;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;

   localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
   localparam logic [CELL_W-1:0] CELL_COUNT   = CELL_W'(CELLS);
   localparam logic [CELL_W-1:0] LAST_CELL    = CELL_W'(CELLS - 1);
   localparam logic [CELL_W-1:0] SCROLL_CELLS = CELL_W'(CELLS - COLUMNS);
   localparam logic [CELL_W-1:0] ROW_STRIDE   = CELL_W'(COLUMNS);
   localparam int TAB_STEP = 8;

   // Character codes.
   localparam logic [CODE_W-1:0] CODE_PRINT_LO = 8'd32;
   localparam logic [CODE_W-1:0] CODE_PRINT_HI = 8'd126;
   localparam logic [CODE_W-1:0] CODE_BACK     = 8'd8;
   localparam logic [CODE_W-1:0] CODE_TAB      = 8'd9;
   localparam logic [CODE_W-1:0] CODE_LINE     = 8'd10;
   localparam logic [CODE_W-1:0] CODE_CLEAR    = 8'd12;
   localparam logic [CODE_W-1:0] CODE_RETURN   = 8'd13;
   localparam logic [CODE_W-1:0] CODE_BLANK    = 8'd32;

   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Register map: register index is paddr[2].
   localparam logic REG_ATTRIBUTE = 1'b0;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd117;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef enum logic [2:0] {
      OP_PRINT,
      OP_BACK,
      OP_TAB,
      OP_LINE,
      OP_CLEAR,
      OP_RETURN,
      OP_NONE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CODE_W-1:0]   code;
      logic [CELL_W-1:0]   index;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } state_type;

   // Linear cell address of a row and column.
   function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_addr = CELL_W'(CELL_W'(row) * ROW_STRIDE) + CELL_W'(col);
   endfunction

endpackage

### hdl/tcce_front.sv
// Front end: accepts request words and decodes them into queue operations.
`timescale 1ns / 1ps

module tcce_front (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [tcce_pkg::CODE_W-1:0] req_char_code,
   input  logic [tcce_pkg::CELL_W-1:0] req_cell_index,
   input  logic                        init_busy,
   input  logic                        queue_full,
   output tcce_pkg::push_type          push
);
   import tcce_pkg::*;

   op_type op;

   always_comb begin
      op = OP_NONE;
      if (req_func == FUNC_READ) begin
         // Reads past the end of the screen return zero without touching memory.
         if (req_cell_index < CELL_COUNT) begin
            op = OP_READ;
         end
      end else if (req_char_code >= CODE_PRINT_LO && req_char_code <= CODE_PRINT_HI) begin
         op = OP_PRINT;
      end else begin
         unique case (req_char_code)
            CODE_BACK:   op = OP_BACK;
            CODE_TAB:    op = OP_TAB;
            CODE_LINE:   op = OP_LINE;
            CODE_CLEAR:  op = OP_CLEAR;
            CODE_RETURN: op = OP_RETURN;
            default:     op = OP_NONE;
         endcase
      end
   end

   assign req_ready        = !init_busy && !queue_full;
   assign push.valid       = req_valid && req_ready;
   assign push.entry.op    = op;
   assign push.entry.code  = req_char_code;
   assign push.entry.index = req_cell_index;

endmodule

### hdl/tcce_queue.sv
// Short queue of decoded operations between front and back.
`timescale 1ns / 1ps

module tcce_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tcce_pkg::push_type    push,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output tcce_pkg::entry_type   head
);
   import tcce_pkg::*;

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full  = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

### hdl/tcce_back.sv
// Back end: cursor, screen memory, scroll and clear sweeps, response register.
`timescale 1ns / 1ps

module tcce_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcce_pkg::ATTR_W-1:0] attribute,
   input  logic                        queue_empty,
   input  tcce_pkg::entry_type         head,
   output logic                        pop,
   output logic                        init_busy,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tcce_pkg::ROW_W-1:0]  rsp_cursor_row,
   output logic [tcce_pkg::COL_W-1:0]  rsp_cursor_col,
   output logic [tcce_pkg::CELL_W-1:0] rsp_cursor_pos,
   output logic [tcce_pkg::DATA_W-1:0] rsp_cell_data
);
   import tcce_pkg::*;

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [CELL_W-1:0]  sweep_ff, sweep_in;
   logic [DATA_W-1:0]  fill_ff, fill_in;
   logic               copy_pend_ff, copy_pend_in;
   logic [CELL_W-1:0]  copy_addr_ff, copy_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  cell_data_ff, cell_data_in;

   logic [DATA_W-1:0]  mem [CELLS];
   logic [DATA_W-1:0]  rdata_ff;
   logic               mem_we;
   logic [CELL_W-1:0]  mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [CELL_W-1:0]  mem_raddr;

   logic               rsp_set;
   logic [DATA_W-1:0]  blank;
   logic [COL_W:0]     tab_sum;
   logic [COL_W:0]     tab_stop;

   assign pop       = (state_ff == ST_IDLE) && !queue_empty && !rsp_valid_ff;
   assign init_busy = state_ff == ST_INIT;
   assign blank     = {attribute, CODE_BLANK};

   // Next tab stop, clamped to the last column.
   always_comb begin
      tab_sum  = {1'b0, col_ff} + (COL_W+1)'(TAB_STEP);
      tab_stop = tab_sum & ~((COL_W+1)'(TAB_STEP - 1));
      if (tab_stop > {1'b0, LAST_COL}) begin
         tab_stop = {1'b0, LAST_COL};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_ff == LAST_CELL) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pop) begin
               if (head.op == OP_READ) begin
                  state_in = ST_READ;
               end else if (head.op == OP_CLEAR) begin
                  state_in = ST_FILL;
               end else if (head.op == OP_LINE && row_ff == LAST_ROW) begin
                  state_in = ST_SCROLL;
               end
            end
         end
         ST_READ:   state_in = ST_IDLE;
         ST_SCROLL: begin
            if (sweep_ff == SCROLL_CELLS) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (sweep_ff == LAST_CELL) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      fill_in      = fill_ff;
      copy_pend_in = 1'b0;
      copy_addr_in = copy_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = fill_ff;
      mem_re       = 1'b0;
      mem_raddr    = head.index;
      rsp_set      = 1'b0;
      cell_data_in = cell_data_ff;

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            sweep_in  = (sweep_ff == LAST_CELL) ? '0 : sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            if (pop) begin
               cell_data_in = '0;
               unique case (head.op)
                  OP_PRINT: begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(row_ff, col_ff);
                     mem_wdata = {attribute, head.code};
                     rsp_set   = 1'b1;
                     if (col_ff != LAST_COL) begin
                        col_in = col_ff + 1'b1;
                     end else if (row_ff != LAST_ROW) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                     end
                  end
                  OP_BACK: begin
                     rsp_set = 1'b1;
                     if (col_ff != '0) col_in = col_ff - 1'b1;
                  end
                  OP_TAB: begin
                     rsp_set = 1'b1;
                     if (col_ff != LAST_COL) col_in = tab_stop[COL_W-1:0];
                  end
                  OP_LINE: begin
                     col_in = '0;
                     if (row_ff != LAST_ROW) begin
                        row_in  = row_ff + 1'b1;
                        rsp_set = 1'b1;
                     end else begin
                        sweep_in = '0;
                     end
                  end
                  OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     sweep_in = '0;
                     fill_in  = blank;
                  end
                  OP_RETURN: begin
                     col_in  = '0;
                     rsp_set = 1'b1;
                  end
                  OP_NONE: begin
                     rsp_set = 1'b1;
                  end
                  OP_READ: begin
                     mem_re = 1'b1;
                  end
                  default: begin
                     rsp_set = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_set      = 1'b1;
            cell_data_in = rdata_ff;
         end
         ST_SCROLL: begin
            // Read one row below, write the word read in the previous cycle.
            if (copy_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = copy_addr_ff;
               mem_wdata = rdata_ff;
            end
            if (sweep_ff != SCROLL_CELLS) begin
               mem_re       = 1'b1;
               mem_raddr    = sweep_ff + ROW_STRIDE;
               copy_pend_in = 1'b1;
               copy_addr_in = sweep_ff;
               sweep_in     = sweep_ff + 1'b1;
            end else begin
               fill_in = blank;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in     = '0;
               rsp_set      = 1'b1;
               cell_data_in = '0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_set || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sweep_ff     <= sweep_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff      <= fill_in;
      copy_addr_ff <= copy_addr_in;
      cell_data_ff <= cell_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // The cursor holds while a response waits, since no new word is popped then.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = row_ff;
   assign rsp_cursor_col = col_ff;
   assign rsp_cursor_pos = cell_addr(row_ff, col_ff);
   assign rsp_cell_data  = cell_data_ff;

endmodule

### hdl/text_console_char_engine.sv
// Top level of the text console character engine with its register port.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | func, char_code, cell_index
//  rsp     | out       | rsp_valid/rsp_ready | cursor_row, cursor_col, cursor_pos, cell_data
//  apb     | in/out    | psel, penable       | pwrite, paddr, pwdata, prdata, pready
//
// A printable or cursor word is answered the cycle after it leaves the queue, and the next word
// leaves only once that answer is taken; a read is answered once the registered memory port returns the cell.
// A line feed on the bottom row copies 1920 cells at one per cycle, then blanks 80 cells.
// A form feed writes all 2000 cells at one per cycle through the single write port.
// After reset a clearing pass zeroes all 2000 cells while req_ready stays low.
// A two-word queue lets requests be taken while the back end sweeps or a response waits.
`timescale 1ns / 1ps

module text_console_char_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [tcce_pkg::CODE_W-1:0] req_char_code,
   input  logic [tcce_pkg::CELL_W-1:0] req_cell_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tcce_pkg::ROW_W-1:0]  rsp_cursor_row,
   output logic [tcce_pkg::COL_W-1:0]  rsp_cursor_col,
   output logic [tcce_pkg::CELL_W-1:0] rsp_cursor_pos,
   output logic [tcce_pkg::DATA_W-1:0] rsp_cell_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tcce_pkg::ADDR_W-1:0] paddr,
   input  logic [tcce_pkg::CSR_W-1:0]  pwdata,
   output logic [tcce_pkg::CSR_W-1:0]  prdata,
   output logic                        pready
);
   import tcce_pkg::*;

   logic [ATTR_W-1:0] attr_ff, attr_in;
   push_type          push;
   entry_type         head;
   logic              queue_full;
   logic              queue_empty;
   logic              pop;
   logic              init_busy;

   assign pready = 1'b1;

   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && paddr[2] == REG_ATTRIBUTE) begin
         attr_in = pwdata[ATTR_W-1:0];
      end
      prdata = (paddr[2] == REG_ATTRIBUTE) ? CSR_W'(attr_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tcce_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .init_busy      (init_busy),
      .queue_full     (queue_full),
      .push           (push)
   );

   tcce_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .empty (queue_empty),
      .head  (head)
   );

   tcce_back u_back (
      .clock          (clock),
      .reset          (reset),
      .attribute      (attr_ff),
      .queue_empty    (queue_empty),
      .head           (head),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data)
   );

endmodule
